>>> hw/rtl/tlt_pkg.sv
// Shared types and constants of the toy language tokenizer.
// Depends on nothing; every other file of the block imports it.
package tlt_pkg;

   // Token kinds as they appear on the result channel.
   localparam logic [3:0] KIND_INT    = 4'd0;
   localparam logic [3:0] KIND_FLOAT  = 4'd1;
   localparam logic [3:0] KIND_STRING = 4'd2;
   localparam logic [3:0] KIND_LET    = 4'd3;
   localparam logic [3:0] KIND_PRINT  = 4'd4;
   localparam logic [3:0] KIND_IDENT  = 4'd5;
   localparam logic [3:0] KIND_PLUS   = 4'd6;
   localparam logic [3:0] KIND_MINUS  = 4'd7;
   localparam logic [3:0] KIND_STAR   = 4'd8;
   localparam logic [3:0] KIND_SLASH  = 4'd9;
   localparam logic [3:0] KIND_EQUAL  = 4'd10;
   localparam logic [3:0] KIND_LPAREN = 4'd11;
   localparam logic [3:0] KIND_RPAREN = 4'd12;
   localparam logic [3:0] KIND_END    = 4'd13;
   localparam logic [3:0] KIND_ERROR  = 4'd14;

   // Keyword prefix codes.
   localparam logic [3:0] KW_NONE  = 4'd0;
   localparam logic [3:0] KW_L     = 4'd1;
   localparam logic [3:0] KW_LE    = 4'd2;
   localparam logic [3:0] KW_LET   = 4'd3;
   localparam logic [3:0] KW_P     = 4'd4;
   localparam logic [3:0] KW_PR    = 4'd5;
   localparam logic [3:0] KW_PRI   = 4'd6;
   localparam logic [3:0] KW_PRIN  = 4'd7;
   localparam logic [3:0] KW_PRINT = 4'd8;

   // Characters the scanner looks for.
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_EQUAL  = 8'h3D;
   localparam logic [7:0] CH_LOW_E  = 8'h65;
   localparam logic [7:0] CH_LOW_I  = 8'h69;
   localparam logic [7:0] CH_LOW_L  = 8'h6C;
   localparam logic [7:0] CH_LOW_N  = 8'h6E;
   localparam logic [7:0] CH_LOW_P  = 8'h70;
   localparam logic [7:0] CH_LOW_R  = 8'h72;
   localparam logic [7:0] CH_LOW_T  = 8'h74;

   // One byte can cause a flushed token, an operator or error, and End.
   localparam int unsigned MAX_RESULTS   = 3;
   localparam int unsigned FIFO_DEPTH    = 4;
   localparam int unsigned FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
   localparam int unsigned FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

   typedef struct packed {
      logic [7:0] code_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [3:0]  token_kind;
      logic [15:0] token_start;
      logic [15:0] token_length;
      logic [7:0]  bad_char;
      logic        run_last;
   } rsp_type;

   // All results of one byte, filled from entry 0 upward.
   typedef struct packed {
      rsp_type [MAX_RESULTS-1:0] items;
      logic [1:0]                count;
   } scan_out_type;

endpackage

>>> hw/rtl/tlt_scan.sv
// Scanner of the toy language tokenizer: mode, position and open token state,
// and the results of one byte. Depends on tlt_pkg.
module tlt_scan
   import tlt_pkg::*;
#(
   parameter int unsigned POSITION_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  req_type      item,
   input  logic         fire,
   output scan_out_type scan_out
);

   typedef enum logic [4:0] {
      MODE_IDLE = 5'b00001,
      MODE_NUM  = 5'b00010,
      MODE_STR  = 5'b00100,
      MODE_WORD = 5'b01000,
      MODE_ERR  = 5'b10000
   } mode_type;

   localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
   localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

   mode_type                 mode_ff, mode_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [POSITION_BITS-1:0] start_ff, start_in;
   logic [POSITION_BITS-1:0] len_ff, len_in;
   logic                     dot_ff, dot_in;
   logic [3:0]               kw_ff, kw_in;

   logic       is_digit, is_alpha, is_space, is_quote, is_dot;
   logic       op_hit;
   logic [3:0] op_kind;
   logic [3:0] kw_next;
   logic       do_flush, do_idle;
   scan_out_type out_c;

   function automatic logic [POSITION_BITS-1:0] sat_inc(input logic [POSITION_BITS-1:0] v);
      return (v == POS_MAX) ? v : v + POS_ONE;
   endfunction

   function automatic rsp_type token_of(input mode_type m, input logic d,
                                        input logic [3:0] k,
                                        input logic [POSITION_BITS-1:0] s,
                                        input logic [POSITION_BITS-1:0] l);
      rsp_type t;
      t = '0;
      if (m == MODE_NUM) begin
         t.token_kind = d ? KIND_FLOAT : KIND_INT;
      end else if (m == MODE_STR) begin
         t.token_kind = KIND_STRING;
      end else if (k == KW_LET) begin
         t.token_kind = KIND_LET;
      end else if (k == KW_PRINT) begin
         t.token_kind = KIND_PRINT;
      end else begin
         t.token_kind = KIND_IDENT;
      end
      t.token_start  = 16'(s);
      t.token_length = 16'(l);
      return t;
   endfunction

   assign is_digit = (item.code_byte >= 8'h30) && (item.code_byte <= 8'h39);
   assign is_alpha = ((item.code_byte >= 8'h61) && (item.code_byte <= 8'h7A)) ||
                     ((item.code_byte >= 8'h41) && (item.code_byte <= 8'h5A));
   assign is_space = (item.code_byte == CH_SPACE) ||
                     ((item.code_byte >= CH_TAB) && (item.code_byte <= CH_CR));
   assign is_quote = (item.code_byte == CH_QUOTE);
   assign is_dot   = (item.code_byte == CH_DOT);

   always_comb begin
      op_hit  = 1'b1;
      op_kind = KIND_PLUS;
      case (item.code_byte)
         CH_PLUS:   op_kind = KIND_PLUS;
         CH_MINUS:  op_kind = KIND_MINUS;
         CH_STAR:   op_kind = KIND_STAR;
         CH_SLASH:  op_kind = KIND_SLASH;
         CH_EQUAL:  op_kind = KIND_EQUAL;
         CH_LPAREN: op_kind = KIND_LPAREN;
         CH_RPAREN: op_kind = KIND_RPAREN;
         default:   op_hit  = 1'b0;
      endcase
   end

   // Keyword prefix tracking for a word that is being extended.
   always_comb begin
      kw_next = KW_NONE;
      case (kw_ff)
         KW_L:    if (item.code_byte == CH_LOW_E) kw_next = KW_LE;
         KW_LE:   if (item.code_byte == CH_LOW_T) kw_next = KW_LET;
         KW_P:    if (item.code_byte == CH_LOW_R) kw_next = KW_PR;
         KW_PR:   if (item.code_byte == CH_LOW_I) kw_next = KW_PRI;
         KW_PRI:  if (item.code_byte == CH_LOW_N) kw_next = KW_PRIN;
         KW_PRIN: if (item.code_byte == CH_LOW_T) kw_next = KW_PRINT;
         default: kw_next = KW_NONE;
      endcase
   end

   always_comb begin
      mode_in  = mode_ff;
      pos_in   = pos_ff;
      start_in = start_ff;
      len_in   = len_ff;
      dot_in   = dot_ff;
      kw_in    = kw_ff;
      out_c    = '0;
      do_flush = 1'b0;
      do_idle  = 1'b0;

      case (mode_ff)
         MODE_NUM: begin
            if (is_digit || is_dot) begin
               len_in = sat_inc(len_ff);
               if (is_dot) dot_in = 1'b1;
            end else begin
               do_flush = 1'b1;
               do_idle  = 1'b1;
            end
         end
         MODE_WORD: begin
            if (is_alpha) begin
               len_in = sat_inc(len_ff);
               kw_in  = kw_next;
            end else begin
               do_flush = 1'b1;
               do_idle  = 1'b1;
            end
         end
         MODE_STR: begin
            // The closing quote is consumed; a NUL ends the string and is
            // then treated as a bad byte.
            if (is_quote) begin
               do_flush = 1'b1;
            end else if (item.code_byte == CH_NUL) begin
               do_flush = 1'b1;
               do_idle  = 1'b1;
            end else begin
               len_in = sat_inc(len_ff);
            end
         end
         MODE_ERR: begin
            mode_in = MODE_ERR;
         end
         default: begin
            mode_in = MODE_IDLE;
            do_idle = 1'b1;
         end
      endcase

      if (do_flush) begin
         out_c.items[out_c.count] = token_of(mode_ff, dot_ff, kw_ff, start_ff, len_ff);
         out_c.count = out_c.count + 2'd1;
         mode_in = MODE_IDLE;
      end

      if (do_idle && !is_space) begin
         if (is_digit) begin
            mode_in  = MODE_NUM;
            start_in = pos_ff;
            len_in   = POS_ONE;
            dot_in   = 1'b0;
         end else if (is_quote) begin
            mode_in  = MODE_STR;
            start_in = sat_inc(pos_ff);
            len_in   = '0;
         end else if (is_alpha) begin
            mode_in  = MODE_WORD;
            start_in = pos_ff;
            len_in   = POS_ONE;
            kw_in    = (item.code_byte == CH_LOW_L) ? KW_L :
                       (item.code_byte == CH_LOW_P) ? KW_P : KW_NONE;
         end else if (op_hit) begin
            out_c.items[out_c.count].token_kind   = op_kind;
            out_c.items[out_c.count].token_start  = 16'(pos_ff);
            out_c.items[out_c.count].token_length = 16'd1;
            out_c.count = out_c.count + 2'd1;
         end else begin
            out_c.items[out_c.count].token_kind   = KIND_ERROR;
            out_c.items[out_c.count].token_start  = 16'(pos_ff);
            out_c.items[out_c.count].token_length = 16'd1;
            out_c.items[out_c.count].bad_char     = item.code_byte;
            out_c.count = out_c.count + 2'd1;
            mode_in = MODE_ERR;
         end
      end

      if (item.last_byte) begin
         if ((mode_in == MODE_NUM) || (mode_in == MODE_STR) || (mode_in == MODE_WORD)) begin
            out_c.items[out_c.count] = token_of(mode_in, dot_in, kw_in, start_in, len_in);
            out_c.count = out_c.count + 2'd1;
         end
         out_c.items[out_c.count].token_kind  = KIND_END;
         out_c.items[out_c.count].token_start = 16'(sat_inc(pos_ff));
         out_c.count = out_c.count + 2'd1;
         // The next text starts from the reset state at offset zero.
         mode_in  = MODE_IDLE;
         pos_in   = '0;
         start_in = '0;
         len_in   = '0;
         dot_in   = 1'b0;
         kw_in    = KW_NONE;
      end else begin
         pos_in = sat_inc(pos_ff);
      end

      if (out_c.count != 2'd0) begin
         out_c.items[out_c.count - 2'd1].run_last = 1'b1;
      end
   end

   assign scan_out = out_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         pos_ff   <= '0;
         start_ff <= '0;
         len_ff   <= '0;
         dot_ff   <= 1'b0;
         kw_ff    <= KW_NONE;
      end else if (fire) begin
         mode_ff  <= mode_in;
         pos_ff   <= pos_in;
         start_ff <= start_in;
         len_ff   <= len_in;
         dot_ff   <= dot_in;
         kw_ff    <= kw_in;
      end
   end

`ifndef SYNTHESIS
   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      fire && item.last_byte |=> (pos_ff == '0) && (mode_ff == MODE_IDLE))
      else $error("scanner did not return to offset zero after the last byte");

   a_pos_advances: assert property (@(posedge clock) disable iff (reset)
      fire && !item.last_byte |=> pos_ff != '0)
      else $error("byte position did not advance");

   a_err_silent: assert property (@(posedge clock) disable iff (reset)
      fire && (mode_ff == MODE_ERR) && !item.last_byte |-> out_c.count == 2'd0)
      else $error("a dropped byte produced a result");

   a_last_emits: assert property (@(posedge clock) disable iff (reset)
      fire && item.last_byte |-> out_c.count != 2'd0)
      else $error("last byte produced no End result");
`endif

endmodule

>>> hw/rtl/tlt_rsp_fifo.sv
// Result queue of the toy language tokenizer: takes up to three results of one
// byte at once, hands out one item per cycle unless stalled. Depends on tlt_pkg.
module tlt_rsp_fifo
   import tlt_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_en,
   input  scan_out_type             in_bundle,
   output logic [FIFO_CNT_BITS-1:0] free_slots,
   output logic                     out_valid,
   input  logic                     out_stall,
   output rsp_type                  out_item
);

   rsp_type                  mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_BITS-1:0] count_ff, count_in;
   logic [FIFO_CNT_BITS-1:0] push_n;
   logic                     pop;

   assign pop        = out_valid && !out_stall;
   assign push_n     = in_en ? FIFO_CNT_BITS'(in_bundle.count) : '0;
   assign out_valid  = (count_ff != '0);
   assign out_item   = mem_ff[rd_ptr_ff];
   assign free_slots = FIFO_CNT_BITS'(FIFO_DEPTH) - count_ff;

   assign count_in  = count_ff + push_n - FIFO_CNT_BITS'(pop);
   assign wr_ptr_in = wr_ptr_ff + FIFO_PTR_BITS'(push_n);
   assign rd_ptr_in = rd_ptr_ff + FIFO_PTR_BITS'(pop);

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
         if (in_en && (2'(i) < in_bundle.count)) begin
            mem_ff[wr_ptr_ff + FIFO_PTR_BITS'(i)] <= in_bundle.items[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      in_en |-> FIFO_CNT_BITS'(in_bundle.count) <= free_slots)
      else $error("result queue written beyond its free space");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FIFO_CNT_BITS'(FIFO_DEPTH))
      else $error("result queue fill count out of range");

   a_pop_only: assert property (@(posedge clock) disable iff (reset)
      pop && (push_n == '0) |=> count_ff == $past(count_ff) - FIFO_CNT_BITS'(1))
      else $error("result queue count did not drop after a read");
`endif

endmodule

>>> hw/rtl/toy_language_tokenizer.sv
// Channel  | Ports                          | Item
// ---------+--------------------------------+-------------------------------------
// request  | req_valid, req_stall, req_item | one source byte and its last flag
// response | rsp_valid, rsp_stall, rsp_item | one token: kind, start, length, etc.
//
// A byte is held in the input register until it is scanned, and its results
// are then written into the result queue, whose head drives rsp_item.
// One byte is taken per cycle while req_stall is low. The result queue holds
// four entries and drains one item per cycle while rsp_stall is low. Reset is
// synchronous and clears all control state.
// req_stall rises when the scanned byte's results do not fit in the queue.
module toy_language_tokenizer
   import tlt_pkg::*;
#(
   parameter int unsigned POSITION_BITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_item,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_item
);

   logic    in_valid_ff, in_valid_in;
   req_type in_item_ff;
   logic    req_accept;
   logic    scan_fire;

   scan_out_type             scan_out;
   logic [FIFO_CNT_BITS-1:0] free_slots;

   // The held byte is scanned once all of its results fit in the queue.
   assign scan_fire  = in_valid_ff && (FIFO_CNT_BITS'(scan_out.count) <= free_slots);
   assign req_stall  = in_valid_ff && !scan_fire;
   assign req_accept = req_valid && !req_stall;

   assign in_valid_in = req_accept || (in_valid_ff && !scan_fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_item_ff <= req_item;
      end
   end

   tlt_scan #(
      .POSITION_BITS(POSITION_BITS)
   ) u_scan (
      .clock    (clock),
      .reset    (reset),
      .item     (in_item_ff),
      .fire     (scan_fire),
      .scan_out (scan_out)
   );

   tlt_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .in_en      (scan_fire),
      .in_bundle  (scan_out),
      .free_slots (free_slots),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .out_item   (rsp_item)
   );

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for the toy language tokenizer: directed texts,
// result backpressure and random token streams, checked token by token.
// Depends on tlt_pkg and toy_language_tokenizer from the RTL.
`timescale 1ns / 1ps

module tb_top;
   import tlt_pkg::*;

   localparam int unsigned POS_BITS    = 16;
   localparam int unsigned CYCLE_LIMIT = 1_000_000;
   localparam int unsigned RANDOM_BYTES = 380;

   typedef enum logic [2:0] {
      SCAN_IDLE,
      SCAN_NUM,
      SCAN_STR,
      SCAN_WORD,
      SCAN_ERR
   } scan_mode_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_item;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_item;

   toy_language_tokenizer #(
      .POSITION_BITS(POS_BITS)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_item (req_item),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_item (rsp_item)
   );

   // Scanner state mirrored from the accepted bytes.
   scan_mode_type       scan_mode;
   logic [POS_BITS-1:0] byte_pos;
   logic [POS_BITS-1:0] open_start;
   logic [POS_BITS-1:0] open_len;
   logic                saw_dot;
   logic [3:0]          kw_prog;

   rsp_type     byte_tokens[$];
   rsp_type     token_q[$];
   logic [7:0]  text_q[$];
   int unsigned mismatches;
   int unsigned cycles;
   int unsigned hold_len;
   bit          steady;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end
   end

   function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   function automatic bit is_space(input logic [7:0] b);
      return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
   endfunction

   function automatic bit is_digit(input logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   function automatic bit is_alpha(input logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
   endfunction

   // Appends one byte to the text that the next send_text call delivers.
   function automatic void put_byte(input logic [7:0] b);
      text_q.insert(text_q.size(), b);
   endfunction

   function automatic void reset_scanner();
      scan_mode  = SCAN_IDLE;
      byte_pos   = '0;
      open_start = '0;
      open_len   = '0;
      saw_dot    = 1'b0;
      kw_prog    = KW_NONE;
   endfunction

   function automatic void add_token(input logic [3:0] kind, input logic [POS_BITS-1:0] start,
                                     input logic [POS_BITS-1:0] len, input logic [7:0] bad);
      rsp_type t;
      t.token_kind   = kind;
      t.token_start  = start[15:0];
      t.token_length = len[15:0];
      t.bad_char     = bad;
      t.run_last     = 1'b0;
      byte_tokens.insert(byte_tokens.size(), t);
   endfunction

   function automatic void flush_open();
      logic [3:0] kind;
      case (scan_mode)
         SCAN_NUM: kind = saw_dot ? KIND_FLOAT : KIND_INT;
         SCAN_STR: kind = KIND_STRING;
         SCAN_WORD: kind = (kw_prog == KW_LET) ? KIND_LET
                         : (kw_prog == KW_PRINT) ? KIND_PRINT : KIND_IDENT;
         default: return;
      endcase
      add_token(kind, open_start, open_len, 8'h00);
      scan_mode = SCAN_IDLE;
   endfunction

   function automatic void advance_keyword(input logic [7:0] b);
      case (kw_prog)
         KW_L:    kw_prog = (b == CH_LOW_E) ? KW_LE : KW_NONE;
         KW_LE:   kw_prog = (b == CH_LOW_T) ? KW_LET : KW_NONE;
         KW_P:    kw_prog = (b == CH_LOW_R) ? KW_PR : KW_NONE;
         KW_PR:   kw_prog = (b == CH_LOW_I) ? KW_PRI : KW_NONE;
         KW_PRI:  kw_prog = (b == CH_LOW_N) ? KW_PRIN : KW_NONE;
         KW_PRIN: kw_prog = (b == CH_LOW_T) ? KW_PRINT : KW_NONE;
         default: kw_prog = KW_NONE;
      endcase
   endfunction

   // Handles a byte seen between tokens: skips blanks, opens a token, emits an operator or error.
   function automatic void start_token(input logic [7:0] b, input logic [POS_BITS-1:0] p);
      logic [3:0] op;
      if (is_space(b)) return;
      if (is_digit(b)) begin
         scan_mode  = SCAN_NUM;
         open_start = p;
         open_len   = POS_BITS'(1);
         saw_dot    = 1'b0;
         return;
      end
      if (b == CH_QUOTE) begin
         scan_mode  = SCAN_STR;
         open_start = sat_inc(p);
         open_len   = '0;
         return;
      end
      if (is_alpha(b)) begin
         scan_mode  = SCAN_WORD;
         open_start = p;
         open_len   = POS_BITS'(1);
         kw_prog    = (b == CH_LOW_L) ? KW_L : (b == CH_LOW_P) ? KW_P : KW_NONE;
         return;
      end
      case (b)
         CH_PLUS:   op = KIND_PLUS;
         CH_MINUS:  op = KIND_MINUS;
         CH_STAR:   op = KIND_STAR;
         CH_SLASH:  op = KIND_SLASH;
         CH_EQUAL:  op = KIND_EQUAL;
         CH_LPAREN: op = KIND_LPAREN;
         CH_RPAREN: op = KIND_RPAREN;
         default:   op = KIND_ERROR;
      endcase
      if (op == KIND_ERROR) begin
         add_token(KIND_ERROR, p, POS_BITS'(1), b);
         scan_mode = SCAN_ERR;
      end else begin
         add_token(op, p, POS_BITS'(1), 8'h00);
      end
   endfunction

   function automatic void scan_byte(input logic [7:0] b, input logic last);
      logic [POS_BITS-1:0] p;
      p = byte_pos;
      byte_tokens.delete();
      case (scan_mode)
         SCAN_NUM: begin
            if (is_digit(b) || b == CH_DOT) begin
               open_len = sat_inc(open_len);
               if (b == CH_DOT) saw_dot = 1'b1;
            end else begin
               flush_open();
               start_token(b, p);
            end
         end
         SCAN_WORD: begin
            if (is_alpha(b)) begin
               open_len = sat_inc(open_len);
               advance_keyword(b);
            end else begin
               flush_open();
               start_token(b, p);
            end
         end
         SCAN_STR: begin
            if (b == CH_QUOTE) begin
               flush_open();
            end else if (b == CH_NUL) begin
               // NUL closes the string and is then reported as a bad byte.
               flush_open();
               start_token(b, p);
            end else begin
               open_len = sat_inc(open_len);
            end
         end
         SCAN_ERR: ;
         default: start_token(b, p);
      endcase
      byte_pos = sat_inc(p);
      if (last) begin
         flush_open();
         add_token(KIND_END, byte_pos, '0, 8'h00);
         reset_scanner();
      end
      if (byte_tokens.size() > 0) byte_tokens[byte_tokens.size()-1].run_last = 1'b1;
      foreach (byte_tokens[i]) token_q.insert(token_q.size(), byte_tokens[i]);
   endfunction

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10)
            $display("token mismatch on %s: expected %0h, got %0h", name, want, got);
      end
   endfunction

   // Predicts on every accepted byte and checks every accepted token, in that order.
   always @(posedge clock) begin
      rsp_type want;
      if (reset === 1'b0) begin
         if (req_valid === 1'b1 && req_stall === 1'b0)
            scan_byte(req_item.code_byte, req_item.last_byte);
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            if (token_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected token: kind %0d start %0d length %0d",
                           rsp_item.token_kind, rsp_item.token_start, rsp_item.token_length);
            end else begin
               want = token_q.pop_front();
               check_field("token_kind", 16'(want.token_kind), 16'(rsp_item.token_kind));
               check_field("token_start", want.token_start, rsp_item.token_start);
               check_field("token_length", want.token_length, rsp_item.token_length);
               check_field("bad_char", 16'(want.bad_char), 16'(rsp_item.bad_char));
               check_field("run_last", 16'(want.run_last), 16'(rsp_item.run_last));
            end
         end
      end
   end

   // Token receiver: a random stall before each item unless steady, or a long hold when one is requested.
   initial begin
      int unsigned n;
      rsp_stall <= 1'b0;
      forever begin
         if (hold_len > 0) begin
            n = hold_len;
            hold_len = 0;
         end else begin
            n = steady ? 0 : $urandom_range(0, 8);
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic last);
      int unsigned gap;
      gap = steady ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= '{code_byte: b, last_byte: last};
      do @(posedge clock); while (req_stall !== 1'b0);
   endtask

   task automatic send_text();
      foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
      text_q.delete();
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (token_q.size() != 0) @(posedge clock);
   endtask

   function automatic void add_str(input string s);
      for (int i = 0; i < s.len(); i++) put_byte(s[i]);
   endfunction

   function automatic logic [7:0] rand_space();
      return ($urandom_range(0, 5) == 0) ? CH_SPACE : 8'($urandom_range(CH_TAB, CH_CR));
   endfunction

   function automatic logic [7:0] rand_letter();
      return ($urandom_range(0, 1) == 0) ? 8'("a" + $urandom_range(0, 25))
                                         : 8'("A" + $urandom_range(0, 25));
   endfunction

   function automatic logic [7:0] rand_digit();
      return 8'("0" + $urandom_range(0, 9));
   endfunction

   // Any byte but the quote and NUL stays inside a string.
   function automatic logic [7:0] rand_string_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(1, 255)); while (b == CH_QUOTE);
      return b;
   endfunction

   function automatic void add_random_token();
      string near[12] = '{"l", "le", "lett", "letx", "p", "pr", "pri", "prin", "printf",
                          "Let", "PRINT", "pl"};
      logic [7:0] ops[7] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_EQUAL, CH_LPAREN,
                             CH_RPAREN};
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (sel < 15) begin
         repeat ($urandom_range(1, 4)) put_byte(rand_digit());
      end else if (sel < 25) begin
         put_byte(rand_digit());
         put_byte(CH_DOT);
         repeat ($urandom_range(0, 3))
            put_byte(($urandom_range(0, 3) == 0) ? CH_DOT : rand_digit());
      end else if (sel < 35) begin
         put_byte(CH_QUOTE);
         repeat ($urandom_range(0, 6)) put_byte(rand_string_byte());
         put_byte(CH_QUOTE);
      end else if (sel < 45) begin
         add_str(($urandom_range(0, 1) == 0) ? "let" : "print");
      end else if (sel < 55) begin
         add_str(near[$urandom_range(0, 11)]);
      end else if (sel < 70) begin
         repeat ($urandom_range(1, 6)) put_byte(rand_letter());
      end else if (sel < 85) begin
         put_byte(ops[$urandom_range(0, 6)]);
      end else if (sel < 95) begin
         repeat ($urandom_range(1, 3)) put_byte(rand_space());
      end else begin
         put_byte(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 1) == 0) put_byte(rand_space());
   endfunction

   task automatic test_directed();
      // Keywords, both number kinds, a string, every operator, and three tokens on the end.
      add_str("let\tx=(1.5+2)*\"a\"-print/x)");
      send_text();
      // NUL inside a string, then dropped bytes after the error.
      add_str("\"q");
      put_byte(CH_NUL);
      put_byte("z");
      put_byte(8'hFF);
      send_text();
      // An unterminated string that holds a high byte and a carriage return.
      put_byte(CH_QUOTE);
      put_byte(8'h80);
      put_byte(CH_CR);
      send_text();
      // Space and line feed to carriage return, then a bad character; the digit after it is dropped.
      add_str(" \n");
      put_byte(8'h0B);
      put_byte(8'h0C);
      put_byte(CH_CR);
      add_str("@7");
      send_text();
      add_str("9");
      send_text();
   endtask

   task automatic test_backpressure();
      hold_len = 300;
      repeat (6) add_str("+-*/=()");
      send_text();
      wait_drained();
   endtask

   task automatic test_pause();
      add_str("let n=12");
      foreach (text_q[i]) send_byte(text_q[i], 1'b0);
      text_q.delete();
      wait_drained();
      add_str("+ print n");
      send_text();
   endtask

   task automatic test_random();
      int unsigned sent;
      sent = 0;
      while (sent < RANDOM_BYTES) begin
         steady = ($urandom_range(0, 4) == 0);
         repeat ($urandom_range(1, 12)) add_random_token();
         case ($urandom_range(0, 9))
            0: begin
               put_byte(CH_QUOTE);
               repeat ($urandom_range(0, 4)) put_byte(rand_string_byte());
            end
            1: begin
               put_byte(CH_QUOTE);
               put_byte(rand_letter());
               put_byte(CH_NUL);
               put_byte(rand_digit());
            end
            default: ;
         endcase
         sent += text_q.size();
         send_text();
      end
      steady = 1'b0;
   endtask

   initial begin
      mismatches = 0;
      cycles     = 0;
      hold_len   = 0;
      steady     = 1'b0;
      reset_scanner();
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_item  <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_backpressure();
      test_pause();
      test_random();

      wait_drained();
      repeat (10) @(posedge clock);
      if (mismatches == 0 && token_q.size() == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
